// ----- hdl/mtf_pkg.sv -----
package mtf_pkg;

	// request framing
	localparam int unsigned REQ_BYTES = 12;
	localparam logic [3:0]  REQ_LAST_POS = 4'(REQ_BYTES - 1);

	// register pattern window
	localparam int unsigned PATTERN_BASE = 99;
	localparam int unsigned PATTERN_SPAN = 100;
	localparam logic [15:0] PAT_BASE16 = 16'(PATTERN_BASE);
	localparam logic [16:0] PAT_LO = 17'(PATTERN_BASE);
	localparam logic [16:0] PAT_HI = 17'(PATTERN_BASE + PATTERN_SPAN);

	// protocol constants
	localparam logic [15:0] MBAP_PROTOCOL_ID   = 16'h0000;
	localparam logic [15:0] REQ_LENGTH         = 16'h0006;
	localparam logic [7:0]  FC_READ_HOLDING    = 8'h03;
	localparam logic [7:0]  EXC_CODE_BASE      = 8'h80;
	localparam logic [7:0]  EXC_ILLEGAL_FUNC   = 8'h01;
	localparam logic [15:0] EXC_LENGTH         = 16'h0003;
	localparam logic [4:0]  COUNT_CAP          = 5'd27;

	// configuration register indexes and reset values
	localparam logic       CFG_START_ADDR = 1'b0;
	localparam logic       CFG_MAX_COUNT  = 1'b1;
	localparam logic [7:0] START_ADDR_RST = 8'd100;
	localparam logic [4:0] MAX_COUNT_RST  = 5'd20;

	// classified request handed from front to back
	typedef struct packed {
		logic [15:0] tid;
		logic [15:0] pid;
		logic [7:0]  unit;
		logic [7:0]  fc;
		logic [7:0]  start;
		logic [4:0]  count;
		logic        ok;
	} req_desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- hdl/mtf_front.sv -----
module mtf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data,
	input  mtf_pkg::q_stat_t     q_stat,
	output logic                 push,
	output mtf_pkg::req_desc_t   desc
);

	logic [3:0]  byte_pos_q;
	logic [7:0]  hdr_q [mtf_pkg::REQ_BYTES];
	logic [7:0]  start_addr_q;
	logic [4:0]  max_count_q;
	logic [4:0]  max_eff;
	logic [15:0] count16;
	logic        at_last;
	logic        rx_fire;

	assign cfg_ready = 1'b1;
	assign at_last   = (byte_pos_q == mtf_pkg::REQ_LAST_POS);
	assign rx_ready  = !at_last || !q_stat.full;
	assign rx_fire   = rx_valid && rx_ready;
	assign push      = rx_fire && at_last;

	assign max_eff = (max_count_q > mtf_pkg::COUNT_CAP) ? mtf_pkg::COUNT_CAP : max_count_q;
	assign count16 = {hdr_q[10], rx_byte};

	always_comb begin
		desc.tid   = {hdr_q[0], hdr_q[1]};
		desc.pid   = {hdr_q[2], hdr_q[3]};
		desc.unit  = hdr_q[6];
		desc.fc    = hdr_q[7];
		desc.start = hdr_q[9];
		desc.count = count16[4:0];
		desc.ok    = ({hdr_q[2], hdr_q[3]} == mtf_pkg::MBAP_PROTOCOL_ID) &&
			({hdr_q[4], hdr_q[5]} == mtf_pkg::REQ_LENGTH) &&
			(hdr_q[7] == mtf_pkg::FC_READ_HOLDING) &&
			({hdr_q[8], hdr_q[9]} == {8'h00, start_addr_q}) &&
			(count16 <= {11'd0, max_eff});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q   <= '0;
			start_addr_q <= mtf_pkg::START_ADDR_RST;
			max_count_q  <= mtf_pkg::MAX_COUNT_RST;
		end else begin
			if (rx_fire) begin
				byte_pos_q <= at_last ? 4'd0 : byte_pos_q + 4'd1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mtf_pkg::CFG_START_ADDR: start_addr_q <= cfg_data;
					mtf_pkg::CFG_MAX_COUNT:  max_count_q  <= cfg_data[4:0];
					default:                 start_addr_q <= start_addr_q;
				endcase
			end
		end
	end

	// header bytes, no reset
	always_ff @(posedge clk) begin
		if (rx_fire) begin
			hdr_q[byte_pos_q] <= rx_byte;
		end
	end

endmodule

// ----- hdl/mtf_fifo.sv -----
module mtf_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mtf_pkg::req_desc_t   din,
	input  logic                 pop,
	output mtf_pkg::req_desc_t   dout,
	output mtf_pkg::q_stat_t     stat
);

	mtf_pkg::req_desc_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         fill_q;

	assign stat.full  = (fill_q == 2'd2);
	assign stat.empty = (fill_q == 2'd0);
	assign dout       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- hdl/mtf_back.sv -----
module mtf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtf_pkg::req_desc_t   head,
	input  mtf_pkg::q_stat_t     q_stat,
	output logic                 pop,
	output logic                 tx_valid,
	input  logic                 tx_ready,
	output logic [7:0]           tx_byte,
	output logic                 is_exception,
	output logic                 last_byte
);

	logic [5:0]  idx_q;
	logic [15:0] served_q;
	logic [15:0] acc_q;
	logic [8:0]  addr_q;
	logic        tx_valid_q;
	logic [7:0]  tx_byte_q;
	logic        exc_q;
	logic        last_q;

	logic        advance;
	logic [7:0]  nxt_byte;
	logic        nxt_last;
	logic [5:0]  ok_last_idx;
	logic [15:0] rlen;
	logic [15:0] reg_val;
	logic        in_window;
	logic [15:0] diff;
	logic [31:0] prod;

	assign advance     = !q_stat.empty && (!tx_valid_q || tx_ready);
	assign ok_last_idx = 6'd8 + {head.count, 1'b0};
	assign rlen        = {10'd0, head.count, 1'b0} + 16'd3;
	assign in_window   = ({8'd0, addr_q} >= mtf_pkg::PAT_LO) &&
		({8'd0, addr_q} < mtf_pkg::PAT_HI);
	assign reg_val     = in_window ? acc_q : 16'd0;
	assign diff        = {8'd0, head.start} - mtf_pkg::PAT_BASE16;
	assign prod        = diff * served_q;

	always_comb begin
		nxt_last = 1'b0;
		case (idx_q)
			6'd0: nxt_byte = head.tid[15:8];
			6'd1: nxt_byte = head.tid[7:0];
			6'd2: nxt_byte = head.pid[15:8];
			6'd3: nxt_byte = head.pid[7:0];
			6'd4: nxt_byte = head.ok ? rlen[15:8] : mtf_pkg::EXC_LENGTH[15:8];
			6'd5: nxt_byte = head.ok ? rlen[7:0] : mtf_pkg::EXC_LENGTH[7:0];
			6'd6: nxt_byte = head.unit;
			6'd7: nxt_byte = head.ok ? head.fc : head.fc + mtf_pkg::EXC_CODE_BASE;
			6'd8: begin
				nxt_byte = head.ok ? {2'd0, head.count, 1'b0} : mtf_pkg::EXC_ILLEGAL_FUNC;
				nxt_last = !head.ok || (head.count == 5'd0);
			end
			default: begin
				nxt_byte = idx_q[0] ? reg_val[15:8] : reg_val[7:0];
				nxt_last = (idx_q == ok_last_idx);
			end
		endcase
	end

	assign pop          = advance && nxt_last;
	assign tx_valid     = tx_valid_q;
	assign tx_byte      = tx_byte_q;
	assign is_exception = exc_q;
	assign last_byte    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			served_q   <= '0;
			tx_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				tx_valid_q <= 1'b1;
				idx_q      <= nxt_last ? 6'd0 : idx_q + 6'd1;
				if (idx_q == 6'd0 && head.ok) begin
					served_q <= served_q + 16'd1;
				end
			end else if (tx_ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_byte_q <= nxt_byte;
			exc_q     <= !head.ok;
			last_q    <= nxt_last;
			if (idx_q == 6'd1) begin
				acc_q  <= prod[15:0];
				addr_q <= {1'b0, head.start};
			end else if (idx_q >= 6'd10 && !idx_q[0]) begin
				acc_q  <= acc_q + served_q;
				addr_q <= addr_q + 9'd1;
			end
		end
	end

endmodule

// ----- hdl/modbus_tcp_fc03_responder.sv -----
// channel  | direction | handshake             | payload
// rx       | in        | rx_valid / rx_ready   | rx_byte
// tx       | out       | tx_valid / tx_ready   | tx_byte, is_exception, last_byte
// cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one request byte taken and one response byte given per cycle, bar the stalls below
// the twelfth byte queues a request; its response is registered from the queue head
// the twelfth byte stalls only while the two-entry request queue is full
// cfg_ready is always high; arst_n clears position, counter and queue at once
// tx stalls hold the output register and back up the queue, never the rx bytes 1..11
module modbus_tcp_fc03_responder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       tx_valid,
	input  logic       tx_ready,
	output logic [7:0] tx_byte,
	output logic       is_exception,
	output logic       last_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	// classified request from the front, head of queue to the back
	mtf_pkg::req_desc_t push_desc;
	mtf_pkg::req_desc_t head_desc;
	mtf_pkg::q_stat_t   q_stat;
	logic               q_push;
	logic               q_pop;

	// front: assembles each 12-byte request and checks it
	mtf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (q_push),
		.desc      (push_desc)
	);

	// short queue decoupling request parsing from response streaming
	mtf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_desc),
		.pop    (q_pop),
		.dout   (head_desc),
		.stat   (q_stat)
	);

	// back: streams the normal or exception response, one byte a cycle unless tx stalls
	mtf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head_desc),
		.q_stat       (q_stat),
		.pop          (q_pop),
		.tx_valid     (tx_valid),
		.tx_ready     (tx_ready),
		.tx_byte      (tx_byte),
		.is_exception (is_exception),
		.last_byte    (last_byte)
	);

	// queue must never be written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("request queue overflow");

	// back must never retire a request that is not there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("request queue underflow");

	// exception frames always close with the exception code
	a_exc_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid && is_exception && last_byte) |-> (tx_byte == mtf_pkg::EXC_ILLEGAL_FUNC))
		else $error("exception frame closes with wrong byte");

endmodule
